[hdl/dpp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the dispersion phase polynomial block.
// Used by the stream interfaces and the top level; depends on nothing.

package dpp_pkg;

  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 5;
  localparam int FRAC_W   = 28;

  localparam int K_W = 30;
  localparam logic [K_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam int PROD_W_W = DATA_W + K_W;

  localparam int DEV_W = 33;
  localparam int MAG_W = 32;
  localparam int D2_W  = 36;
  localparam int D3_W  = 40;
  localparam int D4_W  = 44;
  localparam int P2_W  = 2 * MAG_W;
  localparam int PH3_W = (D2_W - MAG_W) + MAG_W;
  localparam int F3_W  = D2_W + MAG_W;
  localparam int PH4_W = (D3_W - MAG_W) + MAG_W;
  localparam int F4_W  = D3_W + MAG_W;

  localparam int TERMS    = 3;
  localparam int COEF_W   = 33;
  localparam int POW_W    = D4_W;
  localparam int POW_HI_W = POW_W - MAG_W;
  localparam int TL_W     = MAG_W + COEF_W;
  localparam int TH_W     = POW_HI_W + COEF_W;
  localparam int TFULL_W  = POW_W + COEF_W;
  localparam int TMAG_W   = TFULL_W - FRAC_W;
  localparam int TERM_W   = TMAG_W + 1;
  localparam int SUM_W    = TERM_W + 2;

  localparam int NUM_STAGES = 12;

  localparam int SCALE_QUADRATIC_SHIFT_DEF = 8;
  localparam int SCALE_CUBIC_SHIFT_DEF     = 8;
  localparam int SCALE_QUARTIC_SHIFT_DEF   = 8;

  typedef enum logic [2:0] {
    REG_CENTER      = 3'd0,
    REG_COEF_QUAD   = 3'd1,
    REG_COEF_CUBIC  = 3'd2,
    REG_COEF_QUART  = 3'd3,
    REG_OFFS_QUAD   = 3'd4,
    REG_OFFS_CUBIC  = 3'd5
  } reg_idx_t;

endpackage

[hdl/dpp_wavenumber_if.sv]
`timescale 1ns / 1ps
// Request channel that carries one pixel wavenumber.
// Depends on dpp_pkg for the field width.

interface dpp_wavenumber_if import dpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] raw_wavenumber;

  modport source (output valid, output raw_wavenumber, input ready);
  modport sink   (input valid, input raw_wavenumber, output ready);
endinterface

[hdl/dpp_phase_if.sv]
`timescale 1ns / 1ps
// Request channel that carries one dispersion phase result.
// Depends on dpp_pkg for the field width.

interface dpp_phase_if import dpp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] phase_shift;

  modport source (output valid, output phase_shift, input ready);
  modport sink   (input valid, input phase_shift, output ready);
endinterface

[hdl/dispersion_phase_polynomial.sv]
`timescale 1ns / 1ps
// Dispersion phase polynomial: fixed-point pipeline from pixel wavenumber to phase.
// Depends on dpp_pkg, dpp_wavenumber_if and dpp_phase_if.

// The block takes one pixel wavenumber (unsigned Q4.28) per clock unless stalled and
// returns the saturated Q16.16 phase -(d^2*c1 + d^3*c2 + d^4*c3), where d is the
// wavenumber over two pi minus the center register. The twelve register stages follow
// the chain of multipliers: the scale by 1/(2*pi), the three powers of |d| and the
// three coefficient products, with wide products split into two partial products and
// summed and rounded in the following stage. Each stage has its own valid bit and
// stalls only when it is full and the stage after it cannot take its request, so empty
// stages fill while a result waits on the output. Registers sit at byte addresses 0,
// 4, ..., 20 of the APB port. The user must write them only while the pipeline is
// empty; the block does not check this. c_mag picks up a write in the next cycle.

module dispersion_phase_polynomial import dpp_pkg::*; #(
  parameter int SCALE_QUADRATIC_SHIFT = SCALE_QUADRATIC_SHIFT_DEF,
  parameter int SCALE_CUBIC_SHIFT     = SCALE_CUBIC_SHIFT_DEF,
  parameter int SCALE_QUARTIC_SHIFT   = SCALE_QUARTIC_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  dpp_wavenumber_if.sink     wavenumber,
  dpp_phase_if.source        phase
);

  logic [DATA_W-1:0] center_wavenumber;
  logic [DATA_W-1:0] coef_quadratic;
  logic [DATA_W-1:0] coef_cubic;
  logic [DATA_W-1:0] coef_quartic;
  logic [DATA_W-1:0] offset_quadratic;
  logic [DATA_W-1:0] offset_cubic;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_wavenumber <= '0;
      coef_quadratic    <= '0;
      coef_cubic        <= '0;
      coef_quartic      <= '0;
      offset_quadratic  <= '0;
      offset_cubic      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER:     center_wavenumber <= pwdata;
        REG_COEF_QUAD:  coef_quadratic    <= pwdata;
        REG_COEF_CUBIC: coef_cubic        <= pwdata;
        REG_COEF_QUART: coef_quartic      <= pwdata;
        REG_OFFS_QUAD:  offset_quadratic  <= pwdata;
        REG_OFFS_CUBIC: offset_cubic      <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER:     prdata = center_wavenumber;
      REG_COEF_QUAD:  prdata = coef_quadratic;
      REG_COEF_CUBIC: prdata = coef_cubic;
      REG_COEF_QUART: prdata = coef_quartic;
      REG_OFFS_QUAD:  prdata = offset_quadratic;
      REG_OFFS_CUBIC: prdata = offset_cubic;
      default:        prdata = '0;
    endcase
  end

  // Coefficients: exact 33-bit quadratic and cubic sums, floor shift, then sign and magnitude.
  logic signed [COEF_W-1:0] sum_quad;
  logic signed [COEF_W-1:0] sum_cubic;
  logic signed [COEF_W-1:0] c_val [TERMS];
  logic        [COEF_W-1:0] c_mag [TERMS];
  logic        [TERMS-1:0]  c_neg;

  always_comb begin
    sum_quad  = $signed({coef_quadratic[DATA_W-1], coef_quadratic})
              + $signed({offset_quadratic[DATA_W-1], offset_quadratic});
    sum_cubic = $signed({coef_cubic[DATA_W-1], coef_cubic})
              + $signed({offset_cubic[DATA_W-1], offset_cubic});
    c_val[0]  = sum_quad >>> SCALE_QUADRATIC_SHIFT;
    c_val[1]  = sum_cubic >>> SCALE_CUBIC_SHIFT;
    c_val[2]  = $signed({coef_quartic[DATA_W-1], coef_quartic}) >>> SCALE_QUARTIC_SHIFT;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TERMS; i++) begin
      c_neg[i] <= c_val[i][COEF_W-1];
      c_mag[i] <= c_val[i][COEF_W-1] ? $unsigned(-c_val[i]) : $unsigned(c_val[i]);
    end
  end

  // Per-stage valid bits and advance enables.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;
  logic [NUM_STAGES-1:0] vld_in;
  logic                  in_acc;
  logic                  out_acc;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || phase.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign vld_in          = {vld[NUM_STAGES-2:0], wavenumber.valid};
  assign wavenumber.ready = adv[0];
  assign in_acc          = wavenumber.valid && wavenumber.ready;
  assign out_acc         = phase.valid && phase.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // Datapath registers, named after the stage that loads them.
  logic [PROD_W_W-1:0] s0_prod;
  logic [MAG_W-1:0]    s1_dm;
  logic                s1_dneg;
  logic [P2_W-1:0]     s2_p2;
  logic [MAG_W-1:0]    s2_dm;
  logic                s2_dneg;
  logic [D2_W-1:0]     s3_d2;
  logic [MAG_W-1:0]    s3_dm;
  logic                s3_dneg;
  logic [P2_W-1:0]     s4_pl3;
  logic [PH3_W-1:0]    s4_ph3;
  logic [D2_W-1:0]     s4_d2;
  logic [MAG_W-1:0]    s4_dm;
  logic                s4_dneg;
  logic [D3_W-1:0]     s5_d3;
  logic [D2_W-1:0]     s5_d2;
  logic [MAG_W-1:0]    s5_dm;
  logic                s5_dneg;
  logic [P2_W-1:0]     s6_pl4;
  logic [PH4_W-1:0]    s6_ph4;
  logic [D3_W-1:0]     s6_d3;
  logic [D2_W-1:0]     s6_d2;
  logic                s6_dneg;
  logic [D4_W-1:0]     s7_d4;
  logic [D3_W-1:0]     s7_d3;
  logic [D2_W-1:0]     s7_d2;
  logic                s7_dneg;
  logic [TL_W-1:0]     s8_tl [TERMS];
  logic [TH_W-1:0]     s8_th [TERMS];
  logic [TERMS-1:0]    s8_tneg;
  logic [TMAG_W-1:0]   s9_tmag [TERMS];
  logic [TERMS-1:0]    s9_tneg;
  logic signed [SUM_W-1:0]  s10_sum;
  logic signed [DATA_W-1:0] s11_phase;

  logic [K_W-1:0]           w_q;
  logic signed [DEV_W-1:0]  dev;
  logic [F3_W-1:0]          d3_full;
  logic [F4_W-1:0]          d4_full;
  logic [POW_W-1:0]         pow [TERMS];
  logic [TFULL_W-1:0]       t_full [TERMS];
  logic signed [TERM_W-1:0] t_sgn [TERMS];
  logic signed [SUM_W-1:0]  neg_sum;
  logic                     sat_hi;
  logic                     sat_lo;

  always_comb begin
    w_q     = s0_prod[PROD_W_W-1:DATA_W] + K_W'(s0_prod[DATA_W-1]);
    dev     = $signed({3'b000, w_q}) - $signed({1'b0, center_wavenumber});
    d3_full = {s4_ph3, {MAG_W{1'b0}}} + F3_W'(s4_pl3) + (F3_W'(1) << (FRAC_W - 1));
    d4_full = {s6_ph4, {MAG_W{1'b0}}} + F4_W'(s6_pl4) + (F4_W'(1) << (FRAC_W - 1));
    pow[0]  = POW_W'(s7_d2);
    pow[1]  = POW_W'(s7_d3);
    pow[2]  = s7_d4;
    for (int i = 0; i < TERMS; i++) begin
      t_full[i] = {s8_th[i], {MAG_W{1'b0}}} + TFULL_W'(s8_tl[i])
                + (TFULL_W'(1) << (FRAC_W - 1));
      t_sgn[i]  = s9_tneg[i] ? -$signed({1'b0, s9_tmag[i]}) : $signed({1'b0, s9_tmag[i]});
    end
    neg_sum = -s10_sum;
    sat_hi  = !neg_sum[SUM_W-1] && (neg_sum[SUM_W-2:DATA_W-1] != '0);
    sat_lo  = neg_sum[SUM_W-1] && (neg_sum[SUM_W-2:DATA_W-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_prod <= PROD_W_W'(wavenumber.raw_wavenumber) * PROD_W_W'(INV_TWO_PI_Q32);
    end
    if (adv[1]) begin
      s1_dneg <= dev[DEV_W-1];
      s1_dm   <= dev[DEV_W-1] ? MAG_W'(-dev) : MAG_W'(dev);
    end
    if (adv[2]) begin
      s2_p2   <= P2_W'(s1_dm) * P2_W'(s1_dm);
      s2_dm   <= s1_dm;
      s2_dneg <= s1_dneg;
    end
    if (adv[3]) begin
      s3_d2   <= D2_W'((s2_p2 + (P2_W'(1) << (FRAC_W - 1))) >> FRAC_W);
      s3_dm   <= s2_dm;
      s3_dneg <= s2_dneg;
    end
    if (adv[4]) begin
      s4_pl3  <= P2_W'(s3_d2[MAG_W-1:0]) * P2_W'(s3_dm);
      s4_ph3  <= PH3_W'(s3_d2[D2_W-1:MAG_W]) * PH3_W'(s3_dm);
      s4_d2   <= s3_d2;
      s4_dm   <= s3_dm;
      s4_dneg <= s3_dneg;
    end
    if (adv[5]) begin
      s5_d3   <= d3_full[F3_W-1:FRAC_W];
      s5_d2   <= s4_d2;
      s5_dm   <= s4_dm;
      s5_dneg <= s4_dneg;
    end
    if (adv[6]) begin
      s6_pl4  <= P2_W'(s5_d3[MAG_W-1:0]) * P2_W'(s5_dm);
      s6_ph4  <= PH4_W'(s5_d3[D3_W-1:MAG_W]) * PH4_W'(s5_dm);
      s6_d3   <= s5_d3;
      s6_d2   <= s5_d2;
      s6_dneg <= s5_dneg;
    end
    if (adv[7]) begin
      s7_d4   <= d4_full[F4_W-1:FRAC_W];
      s7_d3   <= s6_d3;
      s7_d2   <= s6_d2;
      s7_dneg <= s6_dneg;
    end
    if (adv[8]) begin
      for (int i = 0; i < TERMS; i++) begin
        s8_tl[i] <= TL_W'(pow[i][MAG_W-1:0]) * TL_W'(c_mag[i]);
        s8_th[i] <= TH_W'(pow[i][POW_W-1:MAG_W]) * TH_W'(c_mag[i]);
      end
      s8_tneg <= {c_neg[2], c_neg[1] ^ s7_dneg, c_neg[0]};
    end
    if (adv[9]) begin
      for (int i = 0; i < TERMS; i++) begin
        s9_tmag[i] <= t_full[i][TFULL_W-1:FRAC_W];
      end
      s9_tneg <= s8_tneg;
    end
    if (adv[10]) begin
      s10_sum <= SUM_W'(t_sgn[0]) + SUM_W'(t_sgn[1]) + SUM_W'(t_sgn[2]);
    end
    if (adv[11]) begin
      priority if (sat_hi) begin
        s11_phase <= {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sat_lo) begin
        s11_phase <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        s11_phase <= neg_sum[DATA_W-1:0];
      end
    end
  end

  assign phase.valid       = vld[NUM_STAGES-1];
  assign phase.phase_shift = s11_phase;

  // The pipeline holds exactly the requests taken in and not yet delivered.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(vld) ==
      $past($countones(vld)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("pipeline occupancy does not match accepted and delivered requests");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld && !phase.ready) |-> !wavenumber.ready)
    else $error("input accepted while every stage is full and output stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (vld == '0) |-> wavenumber.ready)
    else $error("empty pipeline refuses a request");

  a_first_stage: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> vld[0])
    else $error("accepted request did not enter the first stage");

endmodule
